@@ src/button_click_long_press_detector_unit_macros.svh @@
// assertion helpers, sampled on clk, off while rst_n is low
`ifndef BUTTON_CLICK_LONG_PRESS_DETECTOR_UNIT_MACROS_SVH
`define BUTTON_CLICK_LONG_PRESS_DETECTOR_UNIT_MACROS_SVH

`define BCLPD_ASSERT(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("bclpd assertion failed");

`define BCLPD_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("bclpd assertion failed");

`endif

@@ src/bclpd_pkg.sv @@
package bclpd_pkg;

    localparam int unsigned CntW = 8;
    localparam int unsigned CfgIdxW = 8;

    localparam logic [CntW-1:0] CntMax = '1;

    localparam logic [CntW-1:0] DebounceTicksRst  = 8'd3;
    localparam logic [CntW-1:0] ClickGapTicksRst  = 8'd60;
    localparam logic [CntW-1:0] LongPressTicksRst = 8'd200;
    localparam logic [CntW-1:0] RepeatTicksRst    = 8'd20;
    localparam logic [CntW-1:0] ClickLimitRst     = 8'd255;

    typedef enum logic [CfgIdxW-1:0] {
        REG_DEBOUNCE_TICKS   = 8'd0,
        REG_CLICK_GAP_TICKS  = 8'd1,
        REG_LONG_PRESS_TICKS = 8'd2,
        REG_REPEAT_TICKS     = 8'd3,
        REG_CLICK_LIMIT      = 8'd4
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_RELEASED    = 3'd0,
        ST_PRESSED     = 3'd1,
        ST_WAIT_AGAIN  = 3'd2,
        ST_PRESS_AGAIN = 3'd3,
        ST_LONG_HOLD   = 3'd4
    } press_state_t;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_PRESS   = 3'd1,
        EV_RELEASE = 3'd2,
        EV_LONG    = 3'd3,
        EV_REPEAT  = 3'd4,
        EV_SINGLE  = 3'd5,
        EV_DOUBLE  = 3'd6,
        EV_MULTI   = 3'd7
    } event_t;

    typedef struct packed {
        logic            stable_level;
        logic [CntW-1:0] click_count;
        event_t          event_code;
    } result_t;

    function automatic logic [CntW-1:0] inc_sat(input logic [CntW-1:0] v);
        return (v == CntMax) ? v : v + 1'b1;
    endfunction

endpackage

@@ src/button_click_long_press_detector_unit.sv @@
// result: a result beat is registered and appears in the cycle after its input beat is accepted
// throughput: one tick per cycle, set by the single state update per beat;
//   while a result waits the input is held off, and a new beat enters in the cycle it is taken
// reset: rst_n low clears the debouncer, the press machine and the output valid,
//   and returns all configuration registers to their default values
module button_click_long_press_detector_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // raw_level, zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // event_code, click_count, stable_level, zero fill
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    logic [bclpd_pkg::CntW-1:0] debounce_ticks_reg;
    logic [bclpd_pkg::CntW-1:0] click_gap_ticks_reg;
    logic [bclpd_pkg::CntW-1:0] long_press_ticks_reg;
    logic [bclpd_pkg::CntW-1:0] repeat_ticks_reg;
    logic [bclpd_pkg::CntW-1:0] click_limit_reg;

    logic                       level_reg, level_next;
    logic [bclpd_pkg::CntW-1:0] deb_cnt_reg, deb_cnt_next;
    bclpd_pkg::press_state_t    state_reg, state_next;
    logic [bclpd_pkg::CntW-1:0] tick_reg, tick_next;
    logic [bclpd_pkg::CntW-1:0] clicks_reg, clicks_next;
    bclpd_pkg::event_t          event_next;

    logic                       out_valid_reg;
    bclpd_pkg::result_t         result_reg;

    logic                       raw;
    logic                       in_beat;
    logic [bclpd_pkg::CntW-1:0] deb_inc;
    logic [bclpd_pkg::CntW-1:0] tick_inc;
    logic                       held_state;
    logic                       out_level_ok;

    assign raw       = s_tdata[0];
    assign s_tready  = !out_valid_reg || m_tready;
    assign in_beat   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {4'b0000, result_reg};

    // configuration, zero writes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ticks_reg   <= bclpd_pkg::DebounceTicksRst;
            click_gap_ticks_reg  <= bclpd_pkg::ClickGapTicksRst;
            long_press_ticks_reg <= bclpd_pkg::LongPressTicksRst;
            repeat_ticks_reg     <= bclpd_pkg::RepeatTicksRst;
            click_limit_reg      <= bclpd_pkg::ClickLimitRst;
        end
        else if (cfg_valid && cfg_ready && (cfg_data != '0))
        begin
            unique case (cfg_index)
                bclpd_pkg::REG_DEBOUNCE_TICKS:   debounce_ticks_reg   <= cfg_data;
                bclpd_pkg::REG_CLICK_GAP_TICKS:  click_gap_ticks_reg  <= cfg_data;
                bclpd_pkg::REG_LONG_PRESS_TICKS: long_press_ticks_reg <= cfg_data;
                bclpd_pkg::REG_REPEAT_TICKS:     repeat_ticks_reg     <= cfg_data;
                bclpd_pkg::REG_CLICK_LIMIT:      click_limit_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    // debouncer
    always_comb
    begin
        deb_inc      = bclpd_pkg::inc_sat(deb_cnt_reg);
        level_next   = level_reg;
        deb_cnt_next = '0;
        if (raw != level_reg)
        begin
            deb_cnt_next = deb_inc;
            if (deb_inc >= debounce_ticks_reg)
            begin
                level_next   = raw;
                deb_cnt_next = '0;
            end
        end
    end

    assign tick_inc = bclpd_pkg::inc_sat(tick_reg);

    // press machine, next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bclpd_pkg::ST_RELEASED:
            begin
                if (level_next)
                    state_next = bclpd_pkg::ST_PRESSED;
            end
            bclpd_pkg::ST_PRESSED:
            begin
                if (!level_next)
                    state_next = bclpd_pkg::ST_WAIT_AGAIN;
                else if (tick_inc >= long_press_ticks_reg)
                    state_next = bclpd_pkg::ST_LONG_HOLD;
            end
            bclpd_pkg::ST_WAIT_AGAIN:
            begin
                if (level_next)
                    state_next = bclpd_pkg::ST_PRESS_AGAIN;
                else if (tick_inc >= click_gap_ticks_reg)
                    state_next = bclpd_pkg::ST_RELEASED;
            end
            bclpd_pkg::ST_PRESS_AGAIN:
            begin
                if (!level_next)
                    state_next = bclpd_pkg::ST_WAIT_AGAIN;
            end
            bclpd_pkg::ST_LONG_HOLD:
            begin
                if (!level_next)
                    state_next = bclpd_pkg::ST_RELEASED;
            end
            default: state_next = bclpd_pkg::ST_RELEASED;
        endcase
    end

    // press machine, event and counters
    always_comb
    begin
        event_next  = bclpd_pkg::EV_NONE;
        tick_next   = tick_reg;
        clicks_next = clicks_reg;
        unique case (state_reg)
            bclpd_pkg::ST_RELEASED:
            begin
                if (level_next)
                begin
                    event_next  = bclpd_pkg::EV_PRESS;
                    tick_next   = '0;
                    clicks_next = bclpd_pkg::CntW'(1);
                end
            end
            bclpd_pkg::ST_PRESSED:
            begin
                if (!level_next)
                begin
                    event_next = bclpd_pkg::EV_RELEASE;
                    tick_next  = '0;
                end
                else
                begin
                    tick_next = tick_inc;
                    if (tick_inc >= long_press_ticks_reg)
                        event_next = bclpd_pkg::EV_LONG;
                end
            end
            bclpd_pkg::ST_WAIT_AGAIN:
            begin
                if (level_next)
                begin
                    event_next = bclpd_pkg::EV_PRESS;
                    tick_next  = '0;
                    if (clicks_reg < click_limit_reg)
                        clicks_next = clicks_reg + 1'b1;
                end
                else
                begin
                    tick_next = tick_inc;
                    if (tick_inc >= click_gap_ticks_reg)
                    begin
                        if (clicks_reg == bclpd_pkg::CntW'(1))
                            event_next = bclpd_pkg::EV_SINGLE;
                        else if (clicks_reg == bclpd_pkg::CntW'(2))
                            event_next = bclpd_pkg::EV_DOUBLE;
                        else
                            event_next = bclpd_pkg::EV_MULTI;
                    end
                end
            end
            bclpd_pkg::ST_PRESS_AGAIN:
            begin
                if (!level_next)
                begin
                    event_next = bclpd_pkg::EV_RELEASE;
                    tick_next  = '0;
                end
            end
            bclpd_pkg::ST_LONG_HOLD:
            begin
                if (!level_next)
                begin
                    event_next  = bclpd_pkg::EV_RELEASE;
                    tick_next   = '0;
                    clicks_next = '0;
                end
                else if (tick_inc >= repeat_ticks_reg)
                begin
                    event_next = bclpd_pkg::EV_REPEAT;
                    tick_next  = '0;
                end
                else
                begin
                    tick_next = tick_inc;
                end
            end
            default:
            begin
                tick_next   = '0;
                clicks_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg   <= 1'b0;
            deb_cnt_reg <= '0;
            state_reg   <= bclpd_pkg::ST_RELEASED;
            tick_reg    <= '0;
            clicks_reg  <= '0;
        end
        else if (in_beat)
        begin
            level_reg   <= level_next;
            deb_cnt_reg <= deb_cnt_next;
            state_reg   <= state_next;
            tick_reg    <= tick_next;
            clicks_reg  <= clicks_next;
        end
    end

    // result beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_beat)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            result_reg.event_code   <= event_next;
            result_reg.click_count  <= clicks_next;
            result_reg.stable_level <= level_next;
        end
    end

    assign held_state = (state_reg == bclpd_pkg::ST_PRESSED)
                     || (state_reg == bclpd_pkg::ST_PRESS_AGAIN)
                     || (state_reg == bclpd_pkg::ST_LONG_HOLD);
    assign out_level_ok = (result_reg.stable_level == level_reg);

`include "button_click_long_press_detector_unit_macros.svh"

    `BCLPD_ASSERT(a_stall_blocks_input, (out_valid_reg && !m_tready) |-> !s_tready)
    `BCLPD_ASSERT_NEXT(a_beat_gives_result, in_beat, out_valid_reg && out_level_ok)
    `BCLPD_ASSERT(a_held_states_match_level, held_state == level_reg)

endmodule
